// File: rtl/core/dgo_pkg.sv
package dgo_pkg;

  // input opcodes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // field widths and degree saturation
  localparam int unsigned IDX_W = 10;
  localparam int unsigned DEG_W = 10;
  localparam logic [DEG_W-1:0] DEG_MAX = 10'd1023;

  // degree store word: removed mark over the degree
  typedef struct packed {
    logic             removed;
    logic [DEG_W-1:0] degree;
  } deg_word_t;

endpackage

// File: rtl/core/dgo_ram.sv
module dgo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/degeneracy_ordering.sv
// add, close and clear beats are taken while the block stays idle
// step beat: scan the degree store for the live vertex of least degree, mark it removed,
// read its list bounds, walk the list decrementing live in-range neighbors, then emit the result
// one beat at a time; the input stalls for the whole step, result stalls add on
// reset clears counts and the overflow flag; the stores need no clearing pass
module degeneracy_ordering
  import dgo_pkg::*;
#(
  parameter int unsigned MAX_VERTICES  = 1024,
  parameter int unsigned MAX_ADJACENCY = 8192
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [1:0]             opcode,
  input  logic [IDX_W-1:0]       neighbor,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [IDX_W-1:0]       vertex,
  output logic [DEG_W-1:0]       removal_degree,
  output logic                   last,
  output logic                   exhausted,
  output logic                   overflowed
);

  localparam int unsigned VIW = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW  = $clog2(MAX_ADJACENCY);
  localparam int unsigned EW  = $clog2(MAX_ADJACENCY + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SCAN = 4'd1;
  localparam logic [3:0] ST_MARK = 4'd2;
  localparam logic [3:0] ST_RS1  = 4'd3;
  localparam logic [3:0] ST_RS2  = 4'd4;
  localparam logic [3:0] ST_WADJ = 4'd5;
  localparam logic [3:0] ST_WDEG = 4'd6;
  localparam logic [3:0] ST_WUPD = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]       state;
  logic [CW-1:0]    vertex_count;
  logic [EW-1:0]    entry_count;
  logic [CW-1:0]    emitted_count;
  logic [EW-1:0]    last_start;
  logic             overflow_flag;
  logic [CW-1:0]    scan_idx;
  logic             pend;
  logic [VIW-1:0]   pend_idx;
  logic             found;
  logic [VIW-1:0]   best;
  logic [DEG_W-1:0] best_deg;
  logic [EW-1:0]    k;
  logic [EW-1:0]    hi;
  logic [VIW-1:0]   upd_idx;

  logic             accept;
  logic             issue;
  logic [EW-1:0]    close_deg;
  logic             deg_we;
  logic [VIW-1:0]   deg_waddr;
  deg_word_t        deg_wdata;
  logic [VIW-1:0]   deg_raddr;
  deg_word_t        deg_rdata;
  logic             row_we;
  logic [VIW-1:0]   row_raddr;
  logic [EW-1:0]    row_rdata;
  logic             adj_we;
  logic [IDX_W-1:0] adj_rdata;
  logic             add_full;
  logic             vert_full;
  logic             nb_in_range;
  logic             out_free;

  assign item_stall  = (state != ST_IDLE);
  assign accept      = item_valid && !item_stall;
  assign vert_full   = 32'(vertex_count) >= 32'(MAX_VERTICES);
  assign add_full    = vert_full || (32'(entry_count) >= 32'(MAX_ADJACENCY));
  assign issue       = (state == ST_SCAN) && (scan_idx < vertex_count);
  assign close_deg   = entry_count - last_start;
  assign nb_in_range = 32'(adj_rdata) < 32'(vertex_count);
  assign out_free    = !result_valid || !result_stall;

  // write enables for the adjacency and row stores
  assign adj_we = accept && (opcode == OP_ADD) && !add_full;
  assign row_we = accept && (opcode == OP_CLOSE) && !vert_full;

  // degree store port selection
  always_comb begin
    deg_we    = 1'b0;
    deg_waddr = VIW'(vertex_count);
    deg_wdata = '{removed: 1'b0,
                  degree: (32'(close_deg) > 32'(DEG_MAX)) ? DEG_MAX : DEG_W'(close_deg)};
    deg_raddr = VIW'(scan_idx);
    if (row_we) begin
      deg_we = 1'b1;
    end else if (state == ST_MARK) begin
      deg_we    = 1'b1;
      deg_waddr = best;
      deg_wdata = '{removed: 1'b1, degree: best_deg};
    end else if (state == ST_WUPD) begin
      deg_waddr = upd_idx;
      deg_wdata = '{removed: 1'b0, degree: deg_rdata.degree - 1'b1};
      deg_we    = !deg_rdata.removed && (deg_rdata.degree != '0);
    end
    if (state == ST_WDEG) begin
      deg_raddr = VIW'(adj_rdata);
    end
  end

  // row start store holds the end of each list
  assign row_raddr = (state == ST_MARK) ? best - 1'b1 : best;

  dgo_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (VIW'(vertex_count)),
    .wdata (entry_count),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  dgo_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ADJACENCY)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (AW'(entry_count)),
    .wdata (neighbor),
    .raddr (AW'(k)),
    .rdata (adj_rdata)
  );

  dgo_ram #(.WIDTH(DEG_W + 1), .DEPTH(MAX_VERTICES)) u_deg (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      vertex_count  <= '0;
      entry_count   <= '0;
      emitted_count <= '0;
      last_start    <= '0;
      overflow_flag <= 1'b0;
      result_valid  <= 1'b0;
      pend          <= 1'b0;
      found         <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_ADD: begin
                if (add_full) begin
                  overflow_flag <= 1'b1;
                end else begin
                  entry_count <= entry_count + 1'b1;
                end
              end
              OP_CLOSE: begin
                if (vert_full) begin
                  overflow_flag <= 1'b1;
                end else begin
                  vertex_count <= vertex_count + 1'b1;
                  last_start   <= entry_count;
                end
              end
              OP_STEP: begin
                state    <= ST_SCAN;
                scan_idx <= '0;
                pend     <= 1'b0;
                found    <= 1'b0;
              end
              OP_CLEAR: begin
                vertex_count  <= '0;
                entry_count   <= '0;
                emitted_count <= '0;
                last_start    <= '0;
                overflow_flag <= 1'b0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          pend     <= issue;
          pend_idx <= VIW'(scan_idx);
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (pend && !deg_rdata.removed && (!found || deg_rdata.degree < best_deg)) begin
            found    <= 1'b1;
            best     <= pend_idx;
            best_deg <= deg_rdata.degree;
          end
          if (!issue && !pend) begin
            state <= found ? ST_MARK : ST_FIN;
          end
        end
        ST_MARK: begin
          state <= ST_RS1;
        end
        ST_RS1: begin
          k     <= (best == '0) ? '0 : row_rdata;
          state <= ST_RS2;
        end
        ST_RS2: begin
          hi    <= row_rdata;
          state <= ST_WADJ;
        end
        ST_WADJ: begin
          state <= (k < hi) ? ST_WDEG : ST_FIN;
        end
        ST_WDEG: begin
          upd_idx <= VIW'(adj_rdata);
          if (nb_in_range) begin
            state <= ST_WUPD;
          end else begin
            k     <= k + 1'b1;
            state <= ST_WADJ;
          end
        end
        ST_WUPD: begin
          k     <= k + 1'b1;
          state <= ST_WADJ;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (found) begin
              emitted_count <= emitted_count + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // result beat handshake
      if ((state == ST_FIN) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      vertex         <= found ? IDX_W'(best) : '0;
      removal_degree <= found ? best_deg : '0;
      last           <= found && ((emitted_count + 1'b1) >= vertex_count);
      exhausted      <= !found;
      overflowed     <= overflow_flag;
    end
  end

`ifndef SYNTHESIS
  a_exh_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && exhausted) |-> (vertex == '0 && removal_degree == '0 && !last))
    else $error("exhausted beat with nonzero fields");
  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) <= 32'(MAX_ADJACENCY))
    else $error("entry count beyond capacity");
  a_vert_bound: assert property (@(posedge clk) disable iff (rst)
    32'(vertex_count) <= 32'(MAX_VERTICES))
    else $error("vertex count beyond capacity");
  a_walk_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WDEG) |=> (state == ST_WADJ || state == ST_WUPD))
    else $error("neighbor walk left its sequence");
`endif

endmodule

// File: bench/tb_degeneracy_ordering.sv
`timescale 1ns / 1ps

module tb_degeneracy_ordering;
  import dgo_pkg::*;

  localparam int unsigned NVERT = 1024;
  localparam int unsigned NADJ  = 8192;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [IDX_W-1:0] vertex;
    logic [DEG_W-1:0] removal_degree;
    logic             last;
    logic             exhausted;
    logic             overflowed;
  } removal_t;

  // ordering predictor and store of expected removals
  class degree_order_board;
    logic [13:0]      list_start [0:NVERT];
    logic [IDX_W-1:0] nbr_store [0:NADJ-1];
    logic [DEG_W-1:0] live_degree [0:NVERT-1];
    bit               gone [0:NVERT-1];
    int unsigned      nverts, nentries, nremoved;
    bit               ovf;
    removal_t         pending_removals[$];
    int               errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (gone[i]) gone[i] = 0;
      list_start[0] = '0;
      nverts = 0;
      nentries = 0;
      nremoved = 0;
      ovf = 0;
    endfunction

    // predict the effect of one accepted input beat
    function void note_beat(logic [1:0] op, logic [IDX_W-1:0] nb);
      int unsigned d, best, best_deg, lo, hi, u;
      bit found;
      removal_t r;
      case (op)
        OP_ADD: begin
          if (nverts >= NVERT || nentries >= NADJ) ovf = 1;
          else begin
            nbr_store[nentries] = nb;
            nentries++;
          end
        end
        OP_CLOSE: begin
          if (nverts >= NVERT) ovf = 1;
          else begin
            d = nentries - list_start[nverts];
            if (d > DEG_MAX) d = DEG_MAX;
            live_degree[nverts] = d;
            list_start[nverts+1] = nentries;
            nverts++;
          end
        end
        OP_CLEAR: wipe();
        OP_STEP: begin
          found = 0;
          best = 0;
          best_deg = 0;
          for (int i = 0; i < nverts; i++) begin
            if (!gone[i] && (!found || live_degree[i] < best_deg)) begin
              found = 1;
              best = i;
              best_deg = live_degree[i];
            end
          end
          if (!found) begin
            r = '{vertex: '0, removal_degree: '0, last: 0, exhausted: 1, overflowed: ovf};
          end else begin
            gone[best] = 1;
            nremoved++;
            lo = list_start[best];
            hi = list_start[best+1];
            for (int k = lo; k < hi && k < NADJ; k++) begin
              u = nbr_store[k];
              if (u < nverts && !gone[u] && live_degree[u] > 0) live_degree[u]--;
            end
            r = '{vertex: best, removal_degree: best_deg,
                  last: (nremoved >= nverts), exhausted: 0, overflowed: ovf};
          end
          pending_removals.insert(pending_removals.size(), r);
        end
      endcase
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_beat(removal_t got);
      removal_t e;
      if (pending_removals.size() == 0) begin
        $error("result beat with nothing expected: vertex %0d", got.vertex);
        errors++;
        return;
      end
      e = pending_removals.pop_front();
      if (got.vertex !== e.vertex) begin
        $error("vertex exp %0d got %0d", e.vertex, got.vertex); errors++;
      end
      if (got.removal_degree !== e.removal_degree) begin
        $error("removal_degree exp %0d got %0d", e.removal_degree, got.removal_degree);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0b got %0b", e.last, got.last); errors++;
      end
      if (got.exhausted !== e.exhausted) begin
        $error("exhausted exp %0b got %0b", e.exhausted, got.exhausted); errors++;
      end
      if (got.overflowed !== e.overflowed) begin
        $error("overflowed exp %0b got %0b", e.overflowed, got.overflowed); errors++;
      end
    endfunction
  endclass

  logic             clk = 0;
  logic             rst = 1;
  logic             item_valid = 0;
  logic             item_stall;
  logic [1:0]       opcode = OP_ADD;
  logic [IDX_W-1:0] neighbor = '0;
  logic             result_valid;
  logic             result_stall = 1;
  logic [IDX_W-1:0] vertex;
  logic [DEG_W-1:0] removal_degree;
  logic             last, exhausted, overflowed;

  degree_order_board board = new();
  bit          no_idle = 0;
  int unsigned cycles = 0;
  int unsigned rand_items = 0;

  degeneracy_ordering DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  // drive one input beat and wait for its acceptance
  task automatic send(logic [1:0] op, logic [IDX_W-1:0] nb);
    int unsigned g;
    g = idle_draw();
    repeat (g) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    neighbor <= nb;
    do @(posedge clk); while (item_stall);
    board.note_beat(op, nb);
  endtask

  // let the block finish all steps in flight
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_removals.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result side with random stalls
  initial begin
    int unsigned g;
    removal_t got;
    @(negedge rst);
    forever begin
      g = idle_draw();
      if (g > 0) begin
        result_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
      got = '{vertex, removal_degree, last, exhausted, overflowed};
      board.check_beat(got);
    end
  end

  initial begin
    int unsigned n, d, nsteps;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty step, duplicates, self loop, out of range, extremes
    send(OP_STEP, 10'h3ff);
    send(OP_ADD, 10'd1);
    send(OP_ADD, 10'd1);
    send(OP_ADD, 10'd0);
    send(OP_ADD, 10'd1023);
    send(OP_CLOSE, 10'd0);
    send(OP_ADD, 10'd0);
    send(OP_CLOSE, 10'h2aa);
    send(OP_CLOSE, 10'h155);
    send(OP_STEP, 10'd0);
    send(OP_STEP, 10'd0);
    // open list is ignored, then a vertex joins during removal
    send(OP_ADD, 10'd0);
    send(OP_ADD, 10'd2);
    send(OP_STEP, 10'd0);
    send(OP_CLOSE, 10'd0);
    send(OP_STEP, 10'd0);
    send(OP_STEP, 10'd0);
    send(OP_STEP, 10'd0);
    send(OP_CLEAR, 10'd0);
    send(OP_STEP, 10'd0);
    drain();

    // random graphs, mostly well formed
    while (rand_items < 520) begin
      if (($urandom % 8) == 0) no_idle = !no_idle;
      if (board.nverts > 150 || ($urandom % 2)) begin
        send(OP_CLEAR, 10'($urandom));
        rand_items++;
      end
      n = $urandom_range(1, 12);
      for (int v = 0; v < n; v++) begin
        d = $urandom_range(0, 5);
        repeat (d) begin
          if (($urandom % 6) == 0) send(OP_ADD, 10'($urandom));
          else send(OP_ADD, 10'(board.nverts + $urandom_range(0, n + 1) - v));
          rand_items++;
        end
        send(OP_CLOSE, 10'($urandom));
        rand_items++;
      end
      nsteps = n + $urandom_range(0, 2);
      for (int s = 0; s < nsteps; s++) begin
        if (($urandom % 10) == 0) send(2'($urandom), 10'($urandom));
        else send(OP_STEP, 10'($urandom));
        rand_items++;
      end
      if (($urandom % 12) == 0) drain();
    end

    // end of run
    drain();
    repeat (100) @(posedge clk);
    if (board.pending_removals.size() != 0) begin
      $error("%0d expected removals never arrived", board.pending_removals.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/dgo_pkg.sv
rtl/core/dgo_ram.sv
rtl/core/degeneracy_ordering.sv
bench/tb_degeneracy_ordering.sv
